// ----- sv/mhpq_pkg.sv -----
package mhpq_pkg;

    localparam int CAPACITY  = 4096;
    localparam int KEY_BITS  = 32;
    localparam int IN_KEY_W  = 32;
    localparam int MIN_KEY_W = 32;
    localparam int COUNT_W   = 13;

    // node numbers are 1-based heap positions, 1..CAPACITY
    localparam int NODE_W = $clog2(CAPACITY + 1);
    localparam int LEVELS = NODE_W;
    localparam int CELLS  = LEVELS - 1;
    localparam int LVL_W  = $clog2(LEVELS);

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [2*KEY_BITS-1:0] t_pair;
    typedef logic [NODE_W-1:0]     t_node;
    typedef logic [LVL_W-1:0]      t_lvl;

    localparam t_node CAP_NODE = NODE_W'(CAPACITY);

    typedef enum logic [0:0] {
        MODE_INSERT  = 1'b0,
        MODE_EXTRACT = 1'b1
    } t_mode;

    typedef enum logic [0:0] {
        K_INS,
        K_SIFT
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FWAIT,
        ST_BUSY
    } t_state;

    // token handed from one level to the next
    typedef struct packed {
        logic  vld;
        t_kind kind;
        t_key  key;
        t_node node;
        t_lvl  sh;
    } t_tok;

    typedef struct packed {
        logic  vld;
        t_node node;
        t_lvl  lvl;
    } t_fetch;

    typedef struct packed {
        logic vld;
        t_key key;
    } t_up;

    typedef struct packed {
        logic  re;
        t_node raddr;
        logic  we;
        t_node waddr;
        t_pair wdata;
    } t_ram_req;

    function automatic t_key get_key(t_pair p, logic side);
        return side ? p[2*KEY_BITS-1:KEY_BITS] : p[KEY_BITS-1:0];
    endfunction

    function automatic t_pair put_key(t_pair p, logic side, t_key k);
        t_pair q;
        q = p;
        if (side) begin
            q[2*KEY_BITS-1:KEY_BITS] = k;
        end else begin
            q[KEY_BITS-1:0] = k;
        end
        return q;
    endfunction

    function automatic t_lvl msb_idx(t_node v);
        t_lvl idx;
        idx = '0;
        for (int i = 0; i < NODE_W; i++) begin
            if (v[i]) begin
                idx = LVL_W'(i);
            end
        end
        return idx;
    endfunction

    // sibling pairs stored at one level (at least two words)
    function automatic int lvl_pairs(int lvl);
        int base;
        int ent;
        int prs;
        base = 1 << lvl;
        ent  = CAPACITY + 1 - base;
        if (ent > base) begin
            ent = base;
        end
        prs = (ent + 1) >> 1;
        if (prs < 2) begin
            prs = 2;
        end
        return prs;
    endfunction

endpackage

// ----- sv/mhpq_if.sv -----
interface mhpq_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [mhpq_pkg::IN_KEY_W-1:0]  key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

interface mhpq_out_if;
    logic                           valid;
    logic                           ready;
    logic [mhpq_pkg::MIN_KEY_W-1:0] min_key;
    logic                           was_empty;
    logic                           was_full;
    logic [mhpq_pkg::COUNT_W-1:0]   count_after;

    modport source (output valid, output min_key, output was_empty, output was_full,
                    output count_after, input ready);
    modport sink   (input valid, input min_key, input was_empty, input was_full,
                    input count_after, output ready);
endinterface

// ----- sv/mhpq_ram.sv -----
module mhpq_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mhpq_cell.sv -----
module mhpq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mhpq_pkg::t_tok     i_tok,
    output mhpq_pkg::t_tok     o_tok,
    input  mhpq_pkg::t_fetch   i_fetch,
    output mhpq_pkg::t_up      o_fetch,
    input  mhpq_pkg::t_up      i_up,
    output mhpq_pkg::t_up      o_up,
    input  mhpq_pkg::t_node    i_count,
    output logic               o_done,
    output mhpq_pkg::t_ram_req o_ram,
    input  mhpq_pkg::t_pair    i_rdata
);

    // control
    logic            r_act,   n_act;
    logic            r_fetch, n_fetch;
    mhpq_pkg::t_tok  r_tok,   n_tok;
    mhpq_pkg::t_up   r_up,    n_up;
    mhpq_pkg::t_up   r_frsp,  n_frsp;
    logic            r_done,  n_done;
    // payload
    mhpq_pkg::t_kind r_kind,  n_kind;
    mhpq_pkg::t_key  r_key,   n_key;
    mhpq_pkg::t_node r_tgt,   n_tgt;
    mhpq_pkg::t_node r_node,  n_node;
    mhpq_pkg::t_lvl  r_sh,    n_sh;
    logic            r_side,  n_side;
    mhpq_pkg::t_pair r_pair,  n_pair;
    mhpq_pkg::t_node r_addr,  n_addr;

    mhpq_pkg::t_node            node_here;
    mhpq_pkg::t_node            child;
    mhpq_pkg::t_key             cur;
    mhpq_pkg::t_key             lkey;
    mhpq_pkg::t_key             rkey;
    mhpq_pkg::t_key             best;
    logic                       moved;
    logic                       side_c;
    logic [mhpq_pkg::NODE_W:0]  cnt_x;

    always_comb begin
        n_act   = 1'b0;
        n_fetch = r_fetch;
        n_tok   = '0;
        n_up    = '0;
        n_frsp  = '0;
        n_done  = 1'b0;
        n_kind  = r_kind;
        n_key   = r_key;
        n_tgt   = r_tgt;
        n_node  = r_node;
        n_sh    = r_sh;
        n_side  = r_side;
        n_pair  = r_pair;
        n_addr  = r_addr;
        o_ram   = '0;

        node_here = i_tok.node >> i_tok.sh;
        cur       = mhpq_pkg::get_key(i_rdata, r_side);
        lkey      = mhpq_pkg::get_key(i_rdata, 1'b0);
        rkey      = mhpq_pkg::get_key(i_rdata, 1'b1);
        cnt_x     = {1'b0, i_count};
        best      = r_key;
        moved     = 1'b0;
        side_c    = 1'b0;
        child     = '0;

        // read launch
        if (i_fetch.vld) begin
            o_ram.re    = 1'b1;
            o_ram.raddr = i_fetch.node >> 1;
            n_act       = 1'b1;
            n_fetch     = 1'b1;
            n_side      = i_fetch.node[0];
            n_addr      = i_fetch.node >> 1;
        end else if (i_tok.vld) begin
            o_ram.re = 1'b1;
            n_act    = 1'b1;
            n_fetch  = 1'b0;
            n_kind   = i_tok.kind;
            n_key    = i_tok.key;
            n_tgt    = i_tok.node;
            n_sh     = i_tok.sh;
            if (i_tok.kind == mhpq_pkg::K_INS) begin
                o_ram.raddr = node_here >> 1;
                n_addr      = node_here >> 1;
                n_node      = node_here;
                n_side      = node_here[0];
            end else begin
                o_ram.raddr = i_tok.node;
                n_addr      = i_tok.node;
                n_node      = i_tok.node;
            end
        end

        // read data back
        if (r_act) begin
            if (r_fetch) begin
                n_frsp.vld = 1'b1;
                n_frsp.key = cur;
            end else if (r_kind == mhpq_pkg::K_INS) begin
                if (r_sh == '0) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_addr;
                    o_ram.wdata = mhpq_pkg::put_key(i_rdata, r_side, r_key);
                    n_done      = 1'b1;
                end else begin
                    n_tok.vld  = 1'b1;
                    n_tok.kind = mhpq_pkg::K_INS;
                    n_tok.node = r_tgt;
                    n_tok.sh   = r_sh - mhpq_pkg::LVL_W'(1);
                    if (cur > r_key) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_addr;
                        o_ram.wdata = mhpq_pkg::put_key(i_rdata, r_side, r_key);
                        n_tok.key   = cur;
                    end else begin
                        n_tok.key   = r_key;
                    end
                end
            end else begin
                // sift-down: left child always present here
                if (lkey < best) begin
                    best   = lkey;
                    moved  = 1'b1;
                    side_c = 1'b0;
                end
                if (({r_node, 1'b1} <= cnt_x) && (rkey < best)) begin
                    best   = rkey;
                    moved  = 1'b1;
                    side_c = 1'b1;
                end
                child    = {r_node[mhpq_pkg::NODE_W-2:0], side_c};
                n_up.vld = 1'b1;
                n_up.key = best;
                if (!moved) begin
                    n_done = 1'b1;
                end else if ({child, 1'b0} <= cnt_x) begin
                    n_tok.vld  = 1'b1;
                    n_tok.kind = mhpq_pkg::K_SIFT;
                    n_tok.key  = r_key;
                    n_tok.node = child;
                    n_tok.sh   = '0;
                    n_side     = side_c;
                    n_pair     = i_rdata;
                end else begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_addr;
                    o_ram.wdata = mhpq_pkg::put_key(i_rdata, side_c, r_key);
                    n_done      = 1'b1;
                end
            end
        end

        // child level hands a key back into the held slot
        if (i_up.vld) begin
            o_ram.we    = 1'b1;
            o_ram.waddr = r_addr;
            o_ram.wdata = mhpq_pkg::put_key(r_pair, r_side, i_up.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_tok  <= '0;
            r_up   <= '0;
            r_frsp <= '0;
            r_done <= 1'b0;
        end else begin
            r_act  <= n_act;
            r_tok  <= n_tok;
            r_up   <= n_up;
            r_frsp <= n_frsp;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fetch <= n_fetch;
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_tgt   <= n_tgt;
        r_node  <= n_node;
        r_sh    <= n_sh;
        r_side  <= n_side;
        r_pair  <= n_pair;
        r_addr  <= n_addr;
    end

    assign o_tok   = r_tok;
    assign o_up    = r_up;
    assign o_fetch = r_frsp;
    assign o_done  = r_done;

endmodule

// ----- sv/mhpq_ctrl.sv -----
module mhpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mhpq_in_if.sink           i_req,
    mhpq_out_if.source        o_rsp,
    output mhpq_pkg::t_tok    o_tok,
    output mhpq_pkg::t_fetch  o_fetch,
    output mhpq_pkg::t_node   o_count,
    input  mhpq_pkg::t_up     i_up,
    input  mhpq_pkg::t_up     i_fetch,
    input  logic              i_done
);

    mhpq_pkg::t_state               r_state, n_state;
    mhpq_pkg::t_node                r_count, n_count;
    mhpq_pkg::t_tok                 r_tok,   n_tok;
    logic                           r_ovld,  n_ovld;
    mhpq_pkg::t_key                 r_root,  n_root;
    mhpq_pkg::t_node                r_last,  n_last;
    logic [mhpq_pkg::MIN_KEY_W-1:0] r_min,   n_min;
    logic                           r_empty, n_empty;
    logic                           r_full,  n_full;
    logic [mhpq_pkg::COUNT_W-1:0]   r_cnt,   n_cnt;

    logic            accept;
    mhpq_pkg::t_key  in_key;
    mhpq_pkg::t_node tgt;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_tok   = '0;
        n_ovld  = r_ovld;
        n_root  = r_root;
        n_last  = r_last;
        n_min   = r_min;
        n_empty = r_empty;
        n_full  = r_full;
        n_cnt   = r_cnt;

        i_req.ready = (r_state == mhpq_pkg::ST_IDLE) && (!r_ovld || o_rsp.ready);
        accept      = i_req.valid && i_req.ready;
        in_key      = mhpq_pkg::KEY_BITS'(i_req.key);
        tgt         = r_count + mhpq_pkg::NODE_W'(1);

        if (o_rsp.ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            mhpq_pkg::ST_IDLE: begin
                if (accept) begin
                    n_ovld  = 1'b1;
                    n_min   = '0;
                    n_empty = 1'b0;
                    n_full  = 1'b0;
                    n_cnt   = mhpq_pkg::COUNT_W'(r_count);
                    if (i_req.mode == mhpq_pkg::MODE_INSERT) begin
                        if (r_count == mhpq_pkg::CAP_NODE) begin
                            n_full = 1'b1;
                        end else begin
                            n_count = tgt;
                            n_cnt   = mhpq_pkg::COUNT_W'(tgt);
                            if (r_count == '0) begin
                                n_root = in_key;
                            end else begin
                                n_tok.vld  = 1'b1;
                                n_tok.kind = mhpq_pkg::K_INS;
                                n_tok.node = tgt;
                                n_tok.sh   = mhpq_pkg::msb_idx(tgt) - mhpq_pkg::LVL_W'(1);
                                if (r_root > in_key) begin
                                    n_root    = in_key;
                                    n_tok.key = r_root;
                                end else begin
                                    n_tok.key = in_key;
                                end
                                n_state = mhpq_pkg::ST_BUSY;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_empty = 1'b1;
                        end else begin
                            n_min   = mhpq_pkg::MIN_KEY_W'(r_root);
                            n_count = r_count - mhpq_pkg::NODE_W'(1);
                            n_cnt   = mhpq_pkg::COUNT_W'(r_count - mhpq_pkg::NODE_W'(1));
                            if (r_count != mhpq_pkg::NODE_W'(1)) begin
                                n_last  = r_count;
                                n_state = mhpq_pkg::ST_FETCH;
                            end
                        end
                    end
                end
            end
            mhpq_pkg::ST_FETCH: begin
                n_state = mhpq_pkg::ST_FWAIT;
            end
            mhpq_pkg::ST_FWAIT: begin
                if (i_fetch.vld) begin
                    if (r_count == mhpq_pkg::NODE_W'(1)) begin
                        n_root  = i_fetch.key;
                        n_state = mhpq_pkg::ST_IDLE;
                    end else begin
                        n_tok.vld  = 1'b1;
                        n_tok.kind = mhpq_pkg::K_SIFT;
                        n_tok.key  = i_fetch.key;
                        n_tok.node = mhpq_pkg::NODE_W'(1);
                        n_tok.sh   = '0;
                        n_state    = mhpq_pkg::ST_BUSY;
                    end
                end
            end
            mhpq_pkg::ST_BUSY: begin
                if (i_up.vld) begin
                    n_root = i_up.key;
                end
                if (i_done) begin
                    n_state = mhpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::ST_IDLE;
            r_count <= '0;
            r_tok   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_tok   <= n_tok;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root  <= n_root;
        r_last  <= n_last;
        r_min   <= n_min;
        r_empty <= n_empty;
        r_full  <= n_full;
        r_cnt   <= n_cnt;
    end

    assign o_tok        = r_tok;
    assign o_count      = r_count;
    assign o_fetch.vld  = (r_state == mhpq_pkg::ST_FETCH);
    assign o_fetch.node = r_last;
    assign o_fetch.lvl  = mhpq_pkg::msb_idx(r_last);

    assign o_rsp.valid       = r_ovld;
    assign o_rsp.min_key     = r_min;
    assign o_rsp.was_empty   = r_empty;
    assign o_rsp.was_full    = r_full;
    assign o_rsp.count_after = r_cnt;

endmodule

// ----- sv/min_heap_priority_queue.sv -----
// channel   dir   handshake      beat payload
// i_req     in    valid/ready    mode, key
// o_rsp     out   valid/ready    min_key, was_empty, was_full, count_after
//
// Root is a register; every lower heap level is one cell with its own pair RAM.
// Each level's cell does a registered read and then a write-back of its pair RAM;
// the deepest level reached is at most 12 here. Trivial beats (first insert, full
// insert, empty extract, extract down to one entry) send no token down the levels.
// Synchronous active-low reset empties the queue; RAM contents are not cleared.
// A result waiting on o_rsp holds off the next i_req beat only when not taken.
module min_heap_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhpq_in_if.sink     i_req,
    mhpq_out_if.source  o_rsp
);

    localparam int CELLS = mhpq_pkg::CELLS;

    mhpq_pkg::t_tok     tok     [CELLS+1];
    mhpq_pkg::t_up      up      [CELLS+1];
    mhpq_pkg::t_up      frsp    [CELLS+1];
    logic               done    [CELLS+1];
    mhpq_pkg::t_fetch   fetch_c [CELLS+1];
    mhpq_pkg::t_ram_req ram_req [CELLS+1];
    mhpq_pkg::t_pair    rdata   [CELLS+1];

    mhpq_pkg::t_fetch   fetch;
    mhpq_pkg::t_up      fetch_rsp;
    mhpq_pkg::t_node    count;
    logic               done_any;

    mhpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_tok   (tok[0]),
        .o_fetch (fetch),
        .o_count (count),
        .i_up    (up[0]),
        .i_fetch (fetch_rsp),
        .i_done  (done_any)
    );

    assign up[CELLS]   = '0;
    assign frsp[0]     = '0;
    assign done[0]     = 1'b0;
    assign fetch_c[0]  = '0;
    assign ram_req[0]  = '0;
    assign rdata[0]    = '0;

    for (genvar l = 1; l <= CELLS; l++) begin : g_lvl
        localparam int              DEPTH = mhpq_pkg::lvl_pairs(l);
        localparam int              AW    = $clog2(DEPTH);
        localparam mhpq_pkg::t_node BASE  = mhpq_pkg::NODE_W'(1) << (l - 1);

        mhpq_pkg::t_node wofs;
        mhpq_pkg::t_node rofs;

        assign fetch_c[l].vld  = fetch.vld && (fetch.lvl == mhpq_pkg::LVL_W'(l));
        assign fetch_c[l].node = fetch.node;
        assign fetch_c[l].lvl  = fetch.lvl;

        mhpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[l-1]),
            .o_tok   (tok[l]),
            .i_fetch (fetch_c[l]),
            .o_fetch (frsp[l]),
            .i_up    (up[l]),
            .o_up    (up[l-1]),
            .i_count (count),
            .o_done  (done[l]),
            .o_ram   (ram_req[l]),
            .i_rdata (rdata[l])
        );

        assign wofs = ram_req[l].waddr - BASE;
        assign rofs = ram_req[l].raddr - BASE;

        mhpq_ram #(
            .WIDTH (2 * mhpq_pkg::KEY_BITS),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_req[l].we),
            .i_waddr (wofs[AW-1:0]),
            .i_wdata (ram_req[l].wdata),
            .i_re    (ram_req[l].re),
            .i_raddr (rofs[AW-1:0]),
            .o_rdata (rdata[l])
        );
    end

    always_comb begin
        fetch_rsp = '0;
        done_any  = 1'b0;
        for (int l = 1; l <= CELLS; l++) begin
            fetch_rsp = fetch_rsp | frsp[l];
            done_any  = done_any | done[l];
        end
    end

endmodule

// ----- sim/mhpq_checker.sv -----
module mhpq_checker
    import mhpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mhpq_in_if   i_req,
    mhpq_out_if  i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_rsp_beats,
    output int   o_full_hits,
    output int   o_empty_hits,
    output int   o_peak
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MIN_KEY_W-1:0] min_key;
        logic                 was_empty;
        logic                 was_full;
        logic [COUNT_W-1:0]   count_after;
    } t_heap_rsp;

    t_key      heap_keys [CAPACITY];
    int        heap_len;
    t_heap_rsp rsp_expected [$];
    int        mismatch_count;
    int        rsp_beats;
    int        full_hits;
    int        empty_hits;
    int        peak_len;

    initial begin
        heap_len       = 0;
        mismatch_count = 0;
        rsp_beats      = 0;
        full_hits      = 0;
        empty_hits     = 0;
        peak_len       = 0;
        o_errors       = 0;
        o_pending      = 0;
        o_rsp_beats    = 0;
        o_full_hits    = 0;
        o_empty_hits   = 0;
        o_peak         = 0;
    end

    // applies one operation to the shadow heap and returns the result beat it yields
    function automatic t_heap_rsp heap_apply(t_mode op, t_key k);
        t_heap_rsp r;
        t_key      t;
        int        pos;
        int        up;
        int        lc;
        int        best;
        r = '0;
        if (op == MODE_INSERT) begin
            if (heap_len >= CAPACITY) begin
                r.was_full = 1'b1;
            end else begin
                pos = heap_len;
                heap_keys[pos] = k;
                heap_len++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_keys[up] <= heap_keys[pos]) begin
                        break;
                    end
                    t = heap_keys[up];
                    heap_keys[up] = heap_keys[pos];
                    heap_keys[pos] = t;
                    pos = up;
                end
            end
        end else if (heap_len == 0) begin
            r.was_empty = 1'b1;
        end else begin
            r.min_key = MIN_KEY_W'(heap_keys[0]);
            heap_len--;
            heap_keys[0] = heap_keys[heap_len];
            pos = 0;
            forever begin
                lc   = 2 * pos + 1;
                best = pos;
                if (lc < heap_len && heap_keys[lc] < heap_keys[best]) begin
                    best = lc;
                end
                if (lc + 1 < heap_len && heap_keys[lc + 1] < heap_keys[best]) begin
                    best = lc + 1;
                end
                if (best == pos) begin
                    break;
                end
                t = heap_keys[best];
                heap_keys[best] = heap_keys[pos];
                heap_keys[pos] = t;
                pos = best;
            end
        end
        r.count_after = COUNT_W'(heap_len);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_heap_rsp want;
        t_heap_rsp got;
        if (!i_rst_n) begin
            heap_len = 0;
            rsp_expected.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.min_key     = i_rsp.min_key;
                got.was_empty   = i_rsp.was_empty;
                got.was_full    = i_rsp.was_full;
                got.count_after = i_rsp.count_after;
                rsp_beats++;
                if (rsp_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected beat: min_key %h empty %b full %b cnt %0d",
                                 $realtime, got.min_key, got.was_empty, got.was_full,
                                 got.count_after);
                    end
                end else begin
                    want = rsp_expected.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: beat %0d expected min_key %h empty %b full %b cnt %0d",
                                     $realtime, rsp_beats, want.min_key, want.was_empty,
                                     want.was_full, want.count_after);
                            $display("%0t: beat %0d      got min_key %h empty %b full %b cnt %0d",
                                     $realtime, rsp_beats, got.min_key, got.was_empty,
                                     got.was_full, got.count_after);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                want = heap_apply(t_mode'(i_req.mode), t_key'(i_req.key));
                if (want.was_full) begin
                    full_hits++;
                end
                if (want.was_empty) begin
                    empty_hits++;
                end
                if (heap_len > peak_len) begin
                    peak_len = heap_len;
                end
                rsp_expected.push_back(want);
            end
        end
        o_errors     <= mismatch_count;
        o_pending    <= rsp_expected.size();
        o_rsp_beats  <= rsp_beats;
        o_full_hits  <= full_hits;
        o_empty_hits <= empty_hits;
        o_peak       <= peak_len;
    end

endmodule

// ----- sim/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mhpq_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_TAIL     = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BEATS    = 400;

    logic i_clk;
    logic i_rst_n;

    mhpq_in_if  req_if ();
    mhpq_out_if rsp_if ();

    int chk_errors;
    int chk_pending;
    int chk_rsp_beats;
    int chk_full_hits;
    int chk_empty_hits;
    int chk_peak;

    int   idle_pct;
    int   stall_pct;
    logic hold_tog;
    logic hold_seen;
    int   hold_left;
    int   held;
    int   quiet_cycles;

    min_heap_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    mhpq_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_errors     (chk_errors),
        .o_pending    (chk_pending),
        .o_rsp_beats  (chk_rsp_beats),
        .o_full_hits  (chk_full_hits),
        .o_empty_hits (chk_empty_hits),
        .o_peak       (chk_peak)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_tog) begin
            hold_seen    <= hold_tog;
            hold_left    <= HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", quiet_cycles);
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_key pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55) begin
            return t_key'($urandom);
        end
        if (sel < 75) begin
            return t_key'($urandom_range(15));
        end
        if (sel < 85) begin
            return t_key'(1) << $urandom_range(KEY_BITS - 1);
        end
        if (sel < 95) begin
            return ~(t_key'(1) << $urandom_range(KEY_BITS - 1));
        end
        return sel[0] ? '1 : '0;
    endfunction

    // drift toward a few hundred entries so sifts run several levels deep
    function automatic t_mode pick_mode();
        int lean;
        lean = (held < 400) ? 62 : 38;
        return ($urandom_range(99) < lean) ? MODE_INSERT : MODE_EXTRACT;
    endfunction

    task automatic send_op(input t_mode op, input t_key k);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= op;
        req_if.key   <= k;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        if (op == MODE_INSERT) begin
            if (held < CAPACITY) begin
                held++;
            end
        end else if (held > 0) begin
            held--;
        end
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (chk_pending != 0);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.mode  = MODE_INSERT;
        req_if.key   = '0;
        rsp_if.ready = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_tog     = 1'b0;
        hold_seen    = 1'b0;
        hold_left    = 0;
        held         = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty extract, extreme and repeated keys, drain past empty
        send_op(MODE_EXTRACT, '0);
        send_op(MODE_INSERT, '0);
        send_op(MODE_INSERT, '1);
        send_op(MODE_INSERT, '1);
        send_op(MODE_INSERT, t_key'(1));
        send_op(MODE_INSERT, t_key'(32'h8000_0000));
        send_op(MODE_INSERT, t_key'(32'h5555_5555));
        send_op(MODE_INSERT, t_key'(32'hAAAA_AAAA));
        send_op(MODE_INSERT, '0);
        send_op(MODE_INSERT, t_key'(32'h7FFF_FFFF));
        repeat (10) send_op(MODE_EXTRACT, '1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 68;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 68;
                end
                default: begin
                    idle_pct = 19;
                    stall_pct <= 19;
                end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ((ph == 0 && n == 250) || (ph == 2 && n == 100)) begin
                    hold_tog <= ~hold_tog;
                end
                send_op(pick_mode(), pick_key());
            end
            wait_drained();
        end

        // drain past empty
        idle_pct = 0;
        stall_pct <= 0;
        while (held > 0) begin
            send_op(MODE_EXTRACT, pick_key());
        end
        send_op(MODE_EXTRACT, '0);
        wait_drained();

        $display("covered %0d beats, %0d refused inserts, %0d empty extracts, peak %0d",
                 chk_rsp_beats, chk_full_hits, chk_empty_hits, chk_peak);
        $display("phases: directed, four idle/stall mixes with long hold-offs, drain");
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
